// ----- rtl/obme_pkg.sv -----
// Shared types and constants for the order book matching engine.
// Used by obme_ctrl, obme_datapath and order_book_matching_engine.
package obme_pkg;

    localparam int DEFAULT_BOOK_DEPTH = 16;

    // Result kinds
    localparam logic [2:0] KIND_TRADE   = 3'd0;
    localparam logic [2:0] KIND_FILLED  = 3'd1;
    localparam logic [2:0] KIND_PARTIAL = 3'd2;
    localparam logic [2:0] KIND_DUP_ID  = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;
    localparam logic [2:0] KIND_FULL    = 3'd5;

    // Operations
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_CANCEL = 1'b1;

    // Sides
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Which result the datapath builds on an emit command
    localparam logic [2:0] EV_TRADE   = 3'd0;
    localparam logic [2:0] EV_INCOME  = 3'd1;
    localparam logic [2:0] EV_RESTING = 3'd2;
    localparam logic [2:0] EV_DUP     = 3'd3;
    localparam logic [2:0] EV_UNKNOWN = 3'd4;
    localparam logic [2:0] EV_FULL    = 3'd5;

    // One resting order
    typedef struct packed {
        logic [31:0] order_ref;
        logic        side;
        logic [31:0] quantity;
        logic [31:0] price;
        logic [31:0] arrival;
    } entry_t;

    // One result
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] order_ref;
        logic [31:0] quantity;
        logic [31:0] price;
    } event_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       fill;
        logic       insert;
        logic       cancel;
        logic       emit;
        logic [2:0] emit_sel;
        logic       flush;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_busy;
        logic op_cancel;
        logic match_found;
        logic best_found;
        logic qty_zero;
        logic free_found;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/order_book_matching_engine.sv -----
// Top level of the limit order book matching engine.
// Depends on obme_pkg, obme_ctrl and obme_datapath.
//
// Limit order book with price-time priority over BOOK_DEPTH resting slots.
// One transaction is worked on at a time: an add or cancel first scans the
// whole book, one slot per cycle through the book memory's read port, and
// reaches its decision once the scan is through. Each fill then emits its
// three results (trade, incoming status, resting status) and, unless it
// completes the incoming order, rescans the book. An add that rests is then
// inserted, and a closing step ends every transaction; results held back
// by out_stall hold it up. The final result of each transaction carries
// last; a cancel that finds its order, an add of zero quantity and an add
// that rests without trading give no result. Results sit in an output
// register, so the next transaction is taken while the last result still
// waits.
module order_book_matching_engine
    import obme_pkg::*;
#(
    parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] order_ref,
    input  logic        side,
    input  logic [31:0] quantity,
    input  logic [31:0] price,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [31:0] event_order_id,
    output logic [31:0] event_quantity,
    output logic [31:0] event_price,
    output logic        last
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    obme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    obme_datapath #(
        .BOOK_DEPTH (BOOK_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .operation      (operation),
        .order_ref      (order_ref),
        .side           (side),
        .quantity       (quantity),
        .price          (price),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .event_order_id (event_order_id),
        .event_quantity (event_quantity),
        .event_price    (event_price),
        .last           (last)
    );

endmodule

// ----- rtl/obme_datapath.sv -----
// Datapath of the order book: book memory, valid bits, scan unit, fill
// arithmetic and the result registers. Depends on obme_pkg.
module obme_datapath
    import obme_pkg::*;
#(
    parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    cmd,
    output dp_stat_t    stat,
    input  logic        operation,
    input  logic [31:0] order_ref,
    input  logic        side,
    input  logic [31:0] quantity,
    input  logic [31:0] price,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [31:0] event_order_id,
    output logic [31:0] event_quantity,
    output logic [31:0] event_price,
    output logic        last
);

    localparam int IDX_W = $clog2(BOOK_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BOOK_DEPTH - 1);

    // Incoming order
    logic        ord_op_reg;
    logic [31:0] ord_id_reg;
    logic        ord_side_reg;
    logic [31:0] ord_qty_reg;
    logic [31:0] ord_price_reg;

    // Book
    entry_t                book_mem [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] valid_reg;
    logic [31:0]           arrival_reg;

    // Scan
    logic             scan_run_reg;
    logic [IDX_W-1:0] scan_cnt_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    entry_t           rd_data_reg;

    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             best_found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    entry_t           best_reg;
    logic [31:0]      best_age_reg;
    logic [31:0]      traded_reg;

    // Results
    logic   pend_valid_reg;
    event_t pend_reg;
    logic   out_valid_reg;
    event_t out_reg;
    logic   out_last_reg;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      traded;
    logic [31:0]      cmp_age;
    logic             cand;
    logic             better;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    event_t           new_ev;
    logic             move_out;

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = BOOK_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Compare stage of the scan
    always_comb
    begin
        cmp_age = arrival_reg - rd_data_reg.arrival;
        cand = valid_reg[cmp_idx_reg] && (rd_data_reg.side != ord_side_reg) &&
               ((ord_side_reg == SIDE_BUY) ? (rd_data_reg.price <= ord_price_reg)
                                           : (rd_data_reg.price >= ord_price_reg));
        better = !best_found_reg ||
                 ((ord_side_reg == SIDE_BUY) ? (rd_data_reg.price < best_reg.price)
                                             : (rd_data_reg.price > best_reg.price)) ||
                 ((rd_data_reg.price == best_reg.price) && (cmp_age > best_age_reg));
    end

    assign traded = (ord_qty_reg < best_reg.quantity) ? ord_qty_reg : best_reg.quantity;

    // Memory write port
    always_comb
    begin
        wr_en   = cmd.fill || cmd.insert;
        wr_addr = cmd.fill ? best_idx_reg : free_idx;
        if (cmd.fill)
        begin
            wr_data          = best_reg;
            wr_data.quantity = best_reg.quantity - traded;
        end
        else
        begin
            wr_data.order_ref = ord_id_reg;
            wr_data.side      = ord_side_reg;
            wr_data.quantity  = ord_qty_reg;
            wr_data.price     = ord_price_reg;
            wr_data.arrival   = arrival_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            book_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= book_mem[scan_cnt_reg];
    end

    // Order latch, scan results and fill arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ord_op_reg    <= operation;
            ord_id_reg    <= order_ref;
            ord_side_reg  <= side;
            ord_qty_reg   <= quantity;
            ord_price_reg <= price;
        end
        if (cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_data_reg.order_ref == ord_id_reg))
        begin
            match_idx_reg <= cmp_idx_reg;
        end
        if (cmp_vld_reg && cand && better)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_reg     <= rd_data_reg;
            best_age_reg <= cmp_age;
        end
        if (cmd.fill)
        begin
            traded_reg        <= traded;
            ord_qty_reg       <= ord_qty_reg - traded;
            best_reg.quantity <= best_reg.quantity - traded;
        end
    end

    // Scan control, valid bits and arrival counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_run_reg    <= 1'b0;
            scan_cnt_reg    <= '0;
            cmp_vld_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            match_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            valid_reg       <= '0;
            arrival_reg     <= '0;
        end
        else
        begin
            cmp_vld_reg <= scan_run_reg;
            cmp_idx_reg <= scan_cnt_reg;
            if (cmd.scan_start)
            begin
                scan_run_reg    <= 1'b1;
                scan_cnt_reg    <= '0;
                match_found_reg <= 1'b0;
                best_found_reg  <= 1'b0;
            end
            else if (scan_run_reg)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == LAST_IDX)
                begin
                    scan_run_reg <= 1'b0;
                    scan_cnt_reg <= '0;
                end
            end
            if (cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_data_reg.order_ref == ord_id_reg))
            begin
                match_found_reg <= 1'b1;
            end
            if (cmp_vld_reg && cand && better)
            begin
                best_found_reg <= 1'b1;
            end
            if (cmd.fill && (best_reg.quantity == traded))
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.cancel)
            begin
                valid_reg[match_idx_reg] <= 1'b0;
            end
            if (cmd.insert)
            begin
                valid_reg[free_idx] <= 1'b1;
                arrival_reg         <= arrival_reg + 1'b1;
            end
        end
    end

    // Result builder
    always_comb
    begin
        new_ev = '0;
        case (cmd.emit_sel)
            EV_TRADE:
            begin
                new_ev.kind     = KIND_TRADE;
                new_ev.quantity = traded_reg;
                new_ev.price    = best_reg.price;
            end
            EV_INCOME:
            begin
                new_ev.order_ref = ord_id_reg;
                if (ord_qty_reg == '0)
                begin
                    new_ev.kind = KIND_FILLED;
                end
                else
                begin
                    new_ev.kind     = KIND_PARTIAL;
                    new_ev.quantity = ord_qty_reg;
                end
            end
            EV_RESTING:
            begin
                new_ev.order_ref = best_reg.order_ref;
                if (best_reg.quantity == '0)
                begin
                    new_ev.kind = KIND_FILLED;
                end
                else
                begin
                    new_ev.kind     = KIND_PARTIAL;
                    new_ev.quantity = best_reg.quantity;
                end
            end
            EV_DUP:
            begin
                new_ev.kind      = KIND_DUP_ID;
                new_ev.order_ref = ord_id_reg;
            end
            EV_UNKNOWN:
            begin
                new_ev.kind      = KIND_UNKNOWN;
                new_ev.order_ref = ord_id_reg;
            end
            default:
            begin
                new_ev.kind      = KIND_FULL;
                new_ev.order_ref = ord_id_reg;
            end
        endcase
    end

    // The newest result waits in pend until we know whether it is the last one
    assign move_out = pend_valid_reg && (cmd.emit || cmd.flush);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_reg <= new_ev;
        end
        if (move_out)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_busy   = scan_run_reg || cmp_vld_reg;
    assign stat.op_cancel   = (ord_op_reg == OP_CANCEL);
    assign stat.match_found = match_found_reg;
    assign stat.best_found  = best_found_reg;
    assign stat.qty_zero    = (ord_qty_reg == '0);
    assign stat.free_found  = free_found;
    assign stat.pend_valid  = pend_valid_reg;
    assign stat.out_free    = !out_valid_reg;

    assign out_valid      = out_valid_reg;
    assign event_kind     = out_reg.kind;
    assign event_order_id = out_reg.order_ref;
    assign event_quantity = out_reg.quantity;
    assign event_price    = out_reg.price;
    assign last           = out_last_reg;

    // A pending result only moves on into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        move_out |-> !out_valid_reg)
        else $error("result overwritten in output register");

    // A fill always has a crossing resting order behind it
    a_fill_best: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> (best_found_reg && !stat.scan_busy && ord_qty_reg != '0))
        else $error("fill without a best resting order");

    // Insertion only into a free slot with something left to rest
    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (free_found && ord_qty_reg != '0))
        else $error("insert without free slot or quantity");

    // A scan is never restarted while one is running
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> (scan_run_reg && !cmp_vld_reg))
        else $error("scan start did not begin a fresh scan");

endmodule

// ----- rtl/obme_ctrl.sv -----
// Controller state machine of the order book: sequences scan, fill,
// result emission, insertion and cancel. Depends on obme_pkg.
module obme_ctrl
    import obme_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_WAIT   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_FILL   = 4'd4;
    localparam logic [3:0] S_TRADE  = 4'd5;
    localparam logic [3:0] S_INCOME = 4'd6;
    localparam logic [3:0] S_REST   = 4'd7;
    localparam logic [3:0] S_INSERT = 4'd8;
    localparam logic [3:0] S_DUP    = 4'd9;
    localparam logic [3:0] S_UNK    = 4'd10;
    localparam logic [3:0] S_FULL   = 4'd11;
    localparam logic [3:0] S_FLUSH  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       first_reg;
    logic       first_next;
    logic       ev_ready;

    // Room for one more result: pend is empty or can move on
    assign ev_ready = !stat.pend_valid || stat.out_free;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    first_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                first_next = 1'b0;
                if (first_reg && stat.op_cancel)
                begin
                    if (stat.match_found)
                    begin
                        cmd.cancel = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_UNK;
                    end
                end
                else if (first_reg && stat.match_found)
                begin
                    state_next = S_DUP;
                end
                else if (stat.qty_zero)
                begin
                    state_next = S_FLUSH;
                end
                else if (stat.best_found)
                begin
                    state_next = S_FILL;
                end
                else if (stat.free_found)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_FULL;
                end
            end
            S_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = S_TRADE;
            end
            S_TRADE:
            begin
                if (ev_ready)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EV_TRADE;
                    state_next   = S_INCOME;
                end
            end
            S_INCOME:
            begin
                if (ev_ready)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EV_INCOME;
                    state_next   = S_REST;
                end
            end
            S_REST:
            begin
                if (ev_ready)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EV_RESTING;
                    state_next   = stat.qty_zero ? S_FLUSH : S_SCAN;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_FLUSH;
            end
            S_DUP:
            begin
                if (ev_ready)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EV_DUP;
                    state_next   = S_FLUSH;
                end
            end
            S_UNK:
            begin
                if (ev_ready)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EV_UNKNOWN;
                    state_next   = S_FLUSH;
                end
            end
            S_FULL:
            begin
                if (ev_ready)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EV_FULL;
                    state_next   = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // last result goes out marked as final
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    // Emission never happens when there is no room for it
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> ev_ready)
        else $error("result emitted without room");

    // A new transaction is only taken with the result path drained of pends
    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !stat.pend_valid)
        else $error("transaction loaded with a pending result");

    // A fill is always followed by its trade result stage
    a_fill_trade: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |=> (state_reg == S_TRADE))
        else $error("fill not followed by trade result");

endmodule

// ----- verif/tb_order_book_matching_engine.sv -----
// Testbench for order_book_matching_engine: directed and random order flow.
// Depends on obme_pkg and the RTL; predicts every result with its own book model.
`timescale 1ns / 1ps

module tb_order_book_matching_engine
    import obme_pkg::*;
();

    localparam int DEPTH = DEFAULT_BOOK_DEPTH;
    localparam int MAX_RESULTS = 48;
    localparam int EXP_DEPTH = 4096;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] order_ref;
        logic [31:0] quantity;
        logic [31:0] price;
        logic        last;
    } book_event_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [31:0] order_ref;
    logic        side;
    logic [31:0] quantity;
    logic [31:0] price;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  event_kind;
    logic [31:0] event_order_id;
    logic [31:0] event_quantity;
    logic [31:0] event_price;
    logic        last;

    // Predictor's copy of the book
    logic        bk_valid   [DEPTH];
    logic [31:0] bk_id      [DEPTH];
    logic        bk_side    [DEPTH];
    logic [31:0] bk_qty     [DEPTH];
    logic [31:0] bk_price   [DEPTH];
    logic [31:0] bk_arrival [DEPTH];
    logic [31:0] arrival_count;

    // Expected results, written by the predictor and read by the checker
    book_event_t exp_fifo [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;

    int          mismatches;
    int          results_seen;
    int          orders_sent;
    longint      cycle_count;
    int          send_idle_pct;
    int          stall_pct;
    logic [31:0] next_id;

    order_book_matching_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .order_ref(order_ref), .side(side),
        .quantity(quantity), .price(price),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_kind(event_kind), .event_order_id(event_order_id),
        .event_quantity(event_quantity), .event_price(event_price),
        .last(last)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int find_resting(logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (bk_valid[i] && bk_id[i] == id)
                return i;
        return -1;
    endfunction

    // Best crossing opposite order: price first, then age
    function automatic int best_crossing(logic sd, logic [31:0] px);
        int best;
        logic better;
        logic [31:0] p;
        best = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!bk_valid[i] || bk_side[i] == sd)
                continue;
            p = bk_price[i];
            if (sd == SIDE_BUY ? (p > px) : (p < px))
                continue;
            if (best < 0)
                best = i;
            else
            begin
                better = (sd == SIDE_BUY) ? (p < bk_price[best]) : (p > bk_price[best]);
                if (!better && p == bk_price[best])
                    better = (arrival_count - bk_arrival[i]) >
                             (arrival_count - bk_arrival[best]);
                if (better)
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic void push_event(logic [2:0] k, logic [31:0] id,
                                       logic [31:0] q, logic [31:0] p);
        book_event_t e;
        e.kind = k; e.order_ref = id; e.quantity = q; e.price = p; e.last = 1'b0;
        exp_fifo[exp_wr % EXP_DEPTH] = e;
        exp_wr++;
    endfunction

    // Apply one transaction to the model book and queue its results
    function automatic void predict_matching(logic op, logic [31:0] id, logic sd,
                                             logic [31:0] qty, logic [31:0] px);
        int first;
        int s;
        logic [31:0] traded;
        first = exp_wr;
        if (op == OP_CANCEL)
        begin
            s = find_resting(id);
            if (s < 0)
                push_event(KIND_UNKNOWN, id, 32'd0, 32'd0);
            else
                bk_valid[s] = 1'b0;
        end
        else if (find_resting(id) >= 0)
            push_event(KIND_DUP_ID, id, 32'd0, 32'd0);
        else
        begin
            while (qty != 0 && (exp_wr - first) + 3 <= MAX_RESULTS)
            begin
                s = best_crossing(sd, px);
                if (s < 0)
                    break;
                traded = (qty < bk_qty[s]) ? qty : bk_qty[s];
                qty -= traded;
                bk_qty[s] -= traded;
                push_event(KIND_TRADE, 32'd0, traded, bk_price[s]);
                if (qty == 0)
                    push_event(KIND_FILLED, id, 32'd0, 32'd0);
                else
                    push_event(KIND_PARTIAL, id, qty, 32'd0);
                if (bk_qty[s] == 0)
                begin
                    push_event(KIND_FILLED, bk_id[s], 32'd0, 32'd0);
                    bk_valid[s] = 1'b0;
                end
                else
                    push_event(KIND_PARTIAL, bk_id[s], bk_qty[s], 32'd0);
            end
            if (qty != 0)
            begin
                s = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (!bk_valid[i])
                    begin
                        s = i;
                        break;
                    end
                if (s < 0)
                    push_event(KIND_FULL, id, 32'd0, 32'd0);
                else
                begin
                    bk_valid[s] = 1'b1; bk_id[s] = id; bk_side[s] = sd;
                    bk_qty[s] = qty; bk_price[s] = px; bk_arrival[s] = arrival_count;
                    arrival_count++;
                end
            end
        end
        if (exp_wr > first)
            exp_fifo[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
    endfunction

    // Send one transaction; the model is updated when it is accepted
    task automatic send_order(logic op, logic [31:0] id, logic sd,
                              logic [31:0] qty, logic [31:0] px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        order_ref <= id;
        side      <= sd;
        quantity  <= qty;
        price     <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_matching(op, id, sd, qty, px);
        orders_sent++;
    endtask

    // Receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        book_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (exp_wr == exp_rd)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d id=%0d", event_kind, event_order_id);
            end
            else
            begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (want.kind !== event_kind || want.order_ref !== event_order_id ||
                    want.quantity !== event_quantity || want.price !== event_price ||
                    want.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp k=%0d id=%0d q=%0d p=%0d l=%0b, %s",
                                 want.kind, want.order_ref, want.quantity, want.price,
                                 want.last,
                                 $sformatf("got k=%0d id=%0d q=%0d p=%0d l=%0b",
                                           event_kind, event_order_id, event_quantity,
                                           event_price, last));
                end
            end
        end
    end

    task automatic drain;
        in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (4 * DEPTH + 20) @(posedge clk);
    endtask

    // Cancel every resting order so a test starts from an empty book
    task automatic clear_book;
        for (int i = 0; i < DEPTH; i++)
            if (bk_valid[i])
                send_order(OP_CANCEL, bk_id[i], 1'b0, 0, 0);
        drain();
    endtask

    task automatic test_directed;
        logic [31:0] top;
        top = 32'hFFFF_FFFF;
        // Simple cross with partial fill of the resting order
        send_order(OP_ADD, 1, SIDE_SELL, 10, 100);
        send_order(OP_ADD, 2, SIDE_BUY, 4, 100);
        // Sweep at extreme price, incoming order rests
        send_order(OP_ADD, 3, SIDE_BUY, 20, top);
        // Duplicate id, unknown cancel, zero quantity, zero id and price
        send_order(OP_ADD, 3, SIDE_SELL, 5, 1);
        send_order(OP_CANCEL, 77, SIDE_SELL, top, top);
        send_order(OP_ADD, 5, SIDE_SELL, 0, 1);
        send_order(OP_ADD, 0, SIDE_SELL, 1, 0);
        send_order(OP_CANCEL, 3, SIDE_BUY, 0, 0);
        send_order(OP_CANCEL, 0, SIDE_BUY, 0, 0);
        // Time priority at equal price, big quantities
        send_order(OP_ADD, 10, SIDE_BUY, top, 50);
        send_order(OP_ADD, 11, SIDE_BUY, 3, 50);
        send_order(OP_ADD, 12, SIDE_SELL, top, 40);
        send_order(OP_ADD, 13, SIDE_SELL, 2, 40);
        drain();
        clear_book();
    endtask

    // Fill the book, hit book full, then sweep all of it
    task automatic test_book_full;
        for (int i = 0; i < DEPTH; i++)
            send_order(OP_ADD, 100 + i, SIDE_SELL, 1 + i, 10 + (i % 4));
        send_order(OP_ADD, 200, SIDE_SELL, 5, 9);
        send_order(OP_ADD, 201, SIDE_BUY, 1000, 20);
        drain();
        clear_book();
    endtask

    task automatic test_random(int count);
        logic op, sd;
        logic [31:0] id, qty, px;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            sd = 1'($urandom_range(1));
            if (pick < 70)
            begin
                op = OP_ADD; id = next_id; next_id++;
                qty = $urandom_range(1, 20); px = $urandom_range(95, 105);
            end
            else if (pick < 85)
            begin
                op = OP_CANCEL;
                id = (n % 2) ? next_id - $urandom_range(1, 12) : $urandom;
                qty = $urandom; px = $urandom;
            end
            else if (pick < 92)
            begin
                op = OP_ADD; id = next_id - $urandom_range(1, 4);
                qty = $urandom_range(1, 20); px = $urandom_range(95, 105);
            end
            else
            begin
                op = 1'($urandom_range(1)); id = $urandom;
                qty = (pick < 95) ? 32'd0 : $urandom; px = $urandom;
            end
            send_order(op, id, sd, qty, px);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0; in_valid = 1'b0; operation = 1'b0; order_ref = '0; side = 1'b0;
        quantity = '0; price = '0; out_stall = 1'b0;
        cycle_count = 0; mismatches = 0; results_seen = 0; orders_sent = 0;
        send_idle_pct = 0; stall_pct = 0; next_id = 1000; arrival_count = '0;
        exp_wr = 0; exp_rd = 0;
        for (int i = 0; i < DEPTH; i++)
            bk_valid[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_book_full();
        test_random(70);
        send_idle_pct = 70;
        test_random(60);
        send_idle_pct = 0; stall_pct = 70;
        test_random(60);
        send_idle_pct = 10; stall_pct = 10;
        test_random(60);

        $display("Sent %0d orders and cancels, checked %0d results, %0d mismatches.",
                 orders_sent, results_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
